// ----- hw/rtl/fccm_pkg.sv -----
// Constants and codes for the FAT cluster chain manager.
// No dependencies.
`default_nettype none

package fccm_pkg;

	localparam int MAX_CLUSTERS = 8192;
	localparam int IDX_W        = $clog2(MAX_CLUSTERS);
	localparam int LEN_W        = IDX_W + 1;
	localparam int ENTRY_W      = 32;
	localparam int CFG_W        = 14;
	localparam int ROOT_W       = 13;

	localparam logic [ENTRY_W-1:0] EOC_MARK = 32'h0FFF_FFFF;

	localparam logic [LEN_W-1:0]  CIU_RESET  = LEN_W'(MAX_CLUSTERS);
	localparam logic [ROOT_W-1:0] ROOT_RESET = ROOT_W'(1);

	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_WRITE  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic CFG_IDX_CIU  = 1'b0;
	localparam logic CFG_IDX_ROOT = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LEN_W-1:0] len_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fat_cluster_chain_manager_unit.sv -----
// FAT cluster chain manager top level: table memory and its sequencer.
// Depends on fccm_pkg.
//
//  channel | signals                                             | dir
//  --------+-----------------------------------------------------+-----
//  in      | in_valid, in_stall, mode, cluster, prev_cluster,    | in
//          | entry_value                                         |
//  out     | out_valid, out_stall, result_value, status          | out
//  cfg     | cfg_write, cfg_index, cfg_data                      | in
//
// One transaction at a time; the table has one registered read and one write
// per cycle, and every entry visited takes a read state and a decide state.
// Create scans for a free entry, marks it and walks the chain to its tail to link it;
// remove frees each cluster of the chain in turn.
// After reset a clearing pass writes every table entry, all MAX_CLUSTERS
// (8192) of them, with in_stall high. A stalled result holds; the next transaction
// is taken meanwhile and waits at its end for the output register.
`default_nettype none

module fat_cluster_chain_manager_unit
	import fccm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [12:0]        cluster,
	input  wire logic [12:0]        prev_cluster,
	input  wire logic [31:0]        entry_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [31:0]             result_value,
	output logic [1:0]              status,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_READ   = 4'd2;
	localparam logic [3:0] S_READ_D = 4'd3;
	localparam logic [3:0] S_WRITE  = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_SCAN_D = 4'd6;
	localparam logic [3:0] S_MARK   = 4'd7;
	localparam logic [3:0] S_WALK   = 4'd8;
	localparam logic [3:0] S_WALK_D = 4'd9;
	localparam logic [3:0] S_LINK   = 4'd10;
	localparam logic [3:0] S_UNDO   = 4'd11;
	localparam logic [3:0] S_PREV   = 4'd12;
	localparam logic [3:0] S_RM     = 4'd13;
	localparam logic [3:0] S_RM_D   = 4'd14;
	localparam logic [3:0] S_RESP   = 4'd15;

	logic [3:0]         state_q;
	len_t               ciu_q;
	logic [ROOT_W-1:0]  root_q;
	len_t               len_q;
	len_t               ptr_q;
	len_t               steps_q;
	idx_t               cur_q;
	idx_t               fresh_q;
	idx_t               prev_q;
	logic               new_chain_q;
	logic [ENTRY_W-1:0] val_q;
	logic [ENTRY_W-1:0] res_q;
	logic [1:0]         stat_q;

	logic               out_valid_q;
	logic [ENTRY_W-1:0] out_res_q;
	logic [1:0]         out_stat_q;

	logic [ENTRY_W-1:0] table_mem [MAX_CLUSTERS];
	logic [ENTRY_W-1:0] rd_data_q;
	idx_t               rd_addr;
	logic               mem_we;
	idx_t               mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	len_t               len_now;
	logic               accept;
	logic               out_load;
	logic [ENTRY_W-1:0] cmp_op;
	logic               ge_len;
	len_t               steps_inc;
	logic               steps_ovf;
	logic               clst_ok;
	logic               prev_ok;

	assign len_now   = (ciu_q > CIU_RESET) ? CIU_RESET : ciu_q;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);
	assign clst_ok   = ({1'b0, cluster} < len_now);
	assign prev_ok   = (prev_cluster == '0) || ({1'b0, prev_cluster} < len_now);

	// shared compare against the table length
	assign cmp_op    = (state_q == S_SCAN) ? ENTRY_W'(ptr_q) : rd_data_q;
	assign ge_len    = (cmp_op >= ENTRY_W'(len_q));
	assign steps_inc = steps_q + len_t'(1);
	assign steps_ovf = (steps_inc >= len_q);

	assign rd_addr   = (state_q == S_SCAN) ? ptr_q[IDX_W-1:0] : cur_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[IDX_W-1:0];
			end
			S_WRITE: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
			end
			S_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = fresh_q;
				mem_wdata = EOC_MARK;
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_wdata = ENTRY_W'(fresh_q);
			end
			S_UNDO: begin
				mem_we    = 1'b1;
				mem_waddr = fresh_q;
			end
			S_PREV: begin
				mem_we    = 1'b1;
				mem_waddr = prev_q;
				mem_wdata = EOC_MARK;
			end
			S_RM_D: begin
				mem_we    = 1'b1;
			end
			default: begin
				mem_we    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q  <= CIU_RESET;
			root_q <= ROOT_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_IDX_CIU) begin
				ciu_q <= cfg_data;
			end else begin
				root_q <= cfg_data[ROOT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + len_t'(1);
					if (ptr_q[IDX_W-1:0] == {IDX_W{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						len_q       <= len_now;
						cur_q       <= cluster;
						prev_q      <= prev_cluster;
						val_q       <= entry_value;
						new_chain_q <= (cluster == '0);
						steps_q     <= '0;
						res_q       <= '0;
						stat_q      <= ST_OK;
						ptr_q       <= len_t'(root_q) + len_t'(1);
						case (mode)
							MODE_CREATE: begin
								if (cluster != '0 && !clst_ok) begin
									stat_q  <= ST_RANGE;
									state_q <= S_RESP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							MODE_REMOVE: begin
								if (!prev_ok || !clst_ok) begin
									stat_q  <= ST_RANGE;
									state_q <= S_RESP;
								end else if (prev_cluster != '0) begin
									state_q <= S_PREV;
								end else begin
									state_q <= S_RM;
								end
							end
							MODE_READ: begin
								if (clst_ok) begin
									state_q <= S_READ;
								end else begin
									stat_q  <= ST_RANGE;
									state_q <= S_RESP;
								end
							end
							default: begin
								if (clst_ok) begin
									state_q <= S_WRITE;
								end else begin
									stat_q  <= ST_RANGE;
									state_q <= S_RESP;
								end
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_READ_D;
				end
				S_READ_D: begin
					res_q   <= rd_data_q;
					state_q <= S_RESP;
				end
				S_WRITE: begin
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (ge_len) begin
						stat_q  <= ST_FULL;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SCAN_D;
					end
				end
				S_SCAN_D: begin
					if (rd_data_q == '0) begin
						fresh_q <= ptr_q[IDX_W-1:0];
						state_q <= S_MARK;
					end else begin
						ptr_q   <= ptr_q + len_t'(1);
						state_q <= S_SCAN;
					end
				end
				S_MARK: begin
					if (new_chain_q) begin
						res_q   <= ENTRY_W'(fresh_q);
						state_q <= S_RESP;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					state_q <= S_WALK_D;
				end
				S_WALK_D: begin
					if (rd_data_q == EOC_MARK) begin
						state_q <= S_LINK;
					end else if (ge_len) begin
						stat_q  <= ST_RANGE;
						state_q <= S_UNDO;
					end else if (steps_ovf) begin
						stat_q  <= ST_OVERFLOW;
						state_q <= S_UNDO;
					end else begin
						steps_q <= steps_inc;
						cur_q   <= rd_data_q[IDX_W-1:0];
						state_q <= S_WALK;
					end
				end
				S_LINK: begin
					res_q   <= ENTRY_W'(fresh_q);
					state_q <= S_RESP;
				end
				S_UNDO: begin
					state_q <= S_RESP;
				end
				S_PREV: begin
					state_q <= S_RM;
				end
				S_RM: begin
					state_q <= S_RM_D;
				end
				S_RM_D: begin
					if (rd_data_q == EOC_MARK || rd_data_q == '0) begin
						state_q <= S_RESP;
					end else if (ge_len) begin
						stat_q  <= ST_RANGE;
						state_q <= S_RESP;
					end else if (steps_ovf) begin
						stat_q  <= ST_OVERFLOW;
						state_q <= S_RESP;
					end else begin
						steps_q <= steps_inc;
						cur_q   <= rd_data_q[IDX_W-1:0];
						state_q <= S_RM;
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign status       = out_stat_q;

	a_err_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q != ST_OK) |-> (out_res_q == '0))
		else $error("nonzero result with error status");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && ptr_q[IDX_W-1:0] == {IDX_W{1'b1}}) |=> (state_q == S_IDLE))
		else $error("clearing pass did not end");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_RESP) |-> !mem_we)
		else $error("table write outside a transaction");

	a_free_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_D && rd_data_q == '0) |=> (state_q == S_MARK))
		else $error("free entry not marked");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for fat_cluster_chain_manager_unit: directed and random chain traffic
// checked against a cluster table tracker kept in the testbench.
// Depends on fccm_pkg and the unit's RTL.
`timescale 1ns / 100ps

import fccm_pkg::*;

typedef struct packed {
	logic [ENTRY_W-1:0] value;
	logic [1:0]         code;
} reply_t;

class chain_tracker;
	logic [ENTRY_W-1:0] fat [MAX_CLUSTERS];
	logic [CFG_W-1:0]   ciu;
	logic [ROOT_W-1:0]  root;
	reply_t             awaited[$];
	int                 errors;

	function new();
		foreach (fat[i]) fat[i] = '0;
		ciu = CIU_RESET;
		root = ROOT_RESET;
		errors = 0;
	endfunction

	function void set_reg(logic idx, logic [CFG_W-1:0] data);
		if (idx == CFG_IDX_CIU) begin
			ciu = data;
		end else begin
			root = data[ROOT_W-1:0];
		end
	endfunction

	function int unsigned tab_len();
		return (ciu < MAX_CLUSTERS) ? ciu : MAX_CLUSTERS;
	endfunction

	function int pending();
		return awaited.size();
	endfunction

	// links walked from start before the tail is found, capped
	function int unsigned tail_distance(int unsigned start);
		int unsigned len, tail, steps, nxt;
		len = tab_len();
		tail = start;
		steps = 0;
		if (start >= len) return 0;
		while (fat[tail] != EOC_MARK && steps <= 300) begin
			nxt = fat[tail];
			if (nxt >= len) return steps;
			steps++;
			tail = nxt;
		end
		return steps;
	endfunction

	function void create_chain(int unsigned start, output logic [31:0] res,
			output logic [1:0] st);
		int unsigned len, fresh, tail, steps, nxt;
		len = tab_len();
		res = '0;
		st = ST_OK;
		if (start != 0 && start >= len) begin
			st = ST_RANGE;
			return;
		end
		fresh = root + 1;
		while (fresh < len && fat[fresh] != 0) fresh++;
		if (fresh >= len) begin
			st = ST_FULL;
			return;
		end
		fat[fresh] = EOC_MARK;
		if (start == 0) begin
			res = fresh;
			return;
		end
		tail = start;
		steps = 0;
		while (fat[tail] != EOC_MARK) begin
			nxt = fat[tail];
			if (nxt >= len) begin
				fat[fresh] = '0;
				st = ST_RANGE;
				return;
			end
			steps++;
			if (steps >= len) begin
				fat[fresh] = '0;
				st = ST_OVERFLOW;
				return;
			end
			tail = nxt;
		end
		fat[tail] = fresh;
		res = fresh;
	endfunction

	function logic [1:0] remove_chain(int unsigned start, int unsigned pred);
		int unsigned len, cur, count, nxt;
		len = tab_len();
		cur = start;
		count = 0;
		if ((pred != 0 && pred >= len) || start >= len) return ST_RANGE;
		if (pred != 0) fat[pred] = EOC_MARK;
		while (1) begin
			if (cur >= len) return ST_RANGE;
			if (count >= len) return ST_OVERFLOW;
			nxt = fat[cur];
			fat[cur] = '0;
			count++;
			if (nxt == EOC_MARK || nxt == 0) return ST_OK;
			cur = nxt;
		end
	endfunction

	function reply_t take_request(logic [1:0] op, logic [12:0] idx, logic [12:0] pred,
			logic [31:0] val);
		reply_t      r;
		logic [31:0] v;
		logic [1:0]  s;
		int unsigned len;
		len = tab_len();
		v = '0;
		s = ST_OK;
		case (op)
			MODE_CREATE: begin
				create_chain(32'(idx), v, s);
			end
			MODE_REMOVE: begin
				s = remove_chain(32'(idx), 32'(pred));
			end
			MODE_READ: begin
				if (idx < len) v = fat[idx];
				else s = ST_RANGE;
			end
			default: begin
				if (idx < len) fat[idx] = val;
				else s = ST_RANGE;
			end
		endcase
		r.value = v;
		r.code = s;
		awaited.push_back(r);
		return r;
	endfunction

	function void match_reply(logic [31:0] value, logic [1:0] code);
		reply_t r;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected result transaction, value %h status %0d",
				$time, value, code);
			errors++;
			return;
		end
		r = awaited.pop_front();
		if (value !== r.value) begin
			$display("%0t: result_value mismatch, expected %h, got %h",
				$time, r.value, value);
			errors++;
		end
		if (code !== r.code) begin
			$display("%0t: status mismatch, expected %0d, got %0d", $time, r.code, code);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int LIMIT = 2_000_000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       mode = MODE_READ;
	logic [12:0]      cluster = '0;
	logic [12:0]      prev_cluster = '0;
	logic [31:0]      entry_value = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [31:0]      result_value;
	logic [1:0]       status;
	logic             cfg_write = 1'b0;
	logic             cfg_index = CFG_IDX_CIU;
	logic [CFG_W-1:0] cfg_data = '0;

	chain_tracker tracker;
	int unsigned  recent[$];
	int           send_gap_pct = 0;
	int           recv_stall_pct = 0;
	int           cycle_count = 0;

	fat_cluster_chain_manager_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.cluster      (cluster),
		.prev_cluster (prev_cluster),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.status       (status),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.match_reply(result_value, status);
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_item(logic [1:0] m, logic [12:0] c, logic [12:0] p, logic [31:0] v);
		reply_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		cluster <= c;
		prev_cluster <= p;
		entry_value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		r = tracker.take_request(m, c, p, v);
		if (m == MODE_CREATE && r.code == ST_OK) begin
			recent.push_back(r.value);
			if (recent.size() > 32) void'(recent.pop_front());
		end
	endtask

	task automatic wait_drained(int tail_cycles);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (tail_cycles) @(posedge clk);
	endtask

	task automatic set_regs(logic [CFG_W-1:0] ciu_data, logic [CFG_W-1:0] root_data);
		in_valid <= 1'b0;
		wait_drained(16);
		cfg_write <= 1'b1;
		cfg_index <= CFG_IDX_CIU;
		cfg_data <= ciu_data;
		@(posedge clk);
		tracker.set_reg(CFG_IDX_CIU, ciu_data);
		cfg_index <= CFG_IDX_ROOT;
		cfg_data <= root_data;
		@(posedge clk);
		tracker.set_reg(CFG_IDX_ROOT, root_data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int unsigned pick_cluster(int unsigned len);
		int r;
		r = $urandom_range(99);
		if (r < 40 && recent.size() > 0) return recent[$urandom_range(recent.size() - 1)];
		if (r < 85 && len > 0) return $urandom_range(len - 1);
		return $urandom_range(8191);
	endfunction

	task automatic random_item(output logic [1:0] m, output logic [12:0] c,
			output logic [12:0] p, output logic [31:0] v);
		int unsigned len;
		int          r;
		len = tracker.tab_len();
		r = $urandom_range(99);
		c = 13'(pick_cluster(len));
		p = 13'($urandom_range(8191));
		v = $urandom;
		if (r < 40) begin
			m = MODE_CREATE;
			if ($urandom_range(99) < 35) c = '0;
			// keep walks short on large tables
			if (c != 0 && tracker.tail_distance(32'(c)) > 300) c = '0;
		end else if (r < 60) begin
			m = MODE_REMOVE;
			if ($urandom_range(99) < 50) p = '0;
			else p = 13'(pick_cluster(len));
		end else if (r < 80) begin
			m = MODE_READ;
		end else begin
			m = MODE_WRITE;
			r = $urandom_range(99);
			if (r < 30) v = '0;
			else if (r < 50) v = EOC_MARK;
			else if (r < 80) v = pick_cluster(len);
		end
	endtask

	task automatic run_phase(int count);
		logic [1:0]  m;
		logic [12:0] c, p;
		logic [31:0] v;
		repeat (count) begin
			random_item(m, c, p, v);
			send_item(m, c, p, v);
		end
	endtask

	initial begin
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 9;
		recv_stall_pct = 68;

		// default registers: full table, root 1
		send_item(MODE_WRITE, 13'd8191, 13'd8191, 32'hFFFF_FFFF);
		send_item(MODE_READ, 13'd8191, 13'd0, 32'h0);
		send_item(MODE_WRITE, 13'd8191, 13'd0, 32'h0);
		send_item(MODE_CREATE, 13'd0, 13'd0, 32'h0);
		send_item(MODE_CREATE, 13'd2, 13'd0, 32'h0);
		send_item(MODE_CREATE, 13'd3, 13'd0, 32'h0);
		send_item(MODE_REMOVE, 13'd3, 13'd2, 32'h0);
		send_item(MODE_READ, 13'd2, 13'd0, 32'h0);
		send_item(MODE_REMOVE, 13'd2, 13'd0, 32'h0);

		set_regs(14'd16, 14'd13);
		send_item(MODE_CREATE, 13'd0, 13'd0, 32'h0);
		send_item(MODE_WRITE, 13'd5, 13'd0, 32'd100);
		send_item(MODE_CREATE, 13'd5, 13'd0, 32'h0);      // link out of range
		send_item(MODE_WRITE, 13'd6, 13'd0, 32'd7);
		send_item(MODE_WRITE, 13'd7, 13'd0, 32'd6);
		send_item(MODE_CREATE, 13'd6, 13'd0, 32'h0);      // loop, walk overflow
		send_item(MODE_CREATE, 13'd0, 13'd0, 32'h0);
		send_item(MODE_CREATE, 13'd0, 13'd0, 32'h0);      // table full
		send_item(MODE_CREATE, 13'd16, 13'd0, 32'h0);     // bad start
		send_item(MODE_REMOVE, 13'd3, 13'd16, 32'h0);
		send_item(MODE_REMOVE, 13'd16, 13'd0, 32'h0);
		send_item(MODE_READ, 13'd16, 13'd0, 32'h0);
		send_item(MODE_WRITE, 13'd16, 13'd0, 32'hFFFF_FFFF);
		send_item(MODE_WRITE, 13'd8, 13'd0, 32'd200);
		send_item(MODE_REMOVE, 13'd8, 13'd0, 32'h0);
		send_item(MODE_REMOVE, 13'd6, 13'd14, 32'h0);     // runs into a free entry

		set_regs(14'd2, 14'd0);
		send_item(MODE_WRITE, 13'd0, 13'd0, 32'd1);
		send_item(MODE_WRITE, 13'd1, 13'd0, 32'd1);
		send_item(MODE_REMOVE, 13'd0, 13'd0, 32'h0);      // remove overflow

		set_regs(14'h3FFF, 14'd8191);
		send_item(MODE_CREATE, 13'd0, 13'd0, 32'h0);
		send_item(MODE_READ, 13'd8191, 13'd0, 32'h0);

		set_regs(14'd32, 14'd1);
		run_phase(140);
		set_regs(14'h3FFF, 14'd8190);
		run_phase(90);
		set_regs(14'd3, 14'd0);
		run_phase(100);

		send_gap_pct = 68;
		recv_stall_pct = 9;
		set_regs(14'd0, 14'd2);
		run_phase(40);
		set_regs(14'd64, 14'h2000 | 14'd40);
		run_phase(150);
		set_regs(14'd8192, 14'd1);
		run_phase(130);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_regs(14'd20, 14'd5);
		run_phase(150);
		set_regs(14'd8191, 14'd8000);
		run_phase(60);

		in_valid <= 1'b0;
		wait_drained(64);
		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
